// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps
// shared types, widths and codes for the sorted priority queue
package spq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int PRI_W               = 16;
    localparam int VAL_W               = 32;
    localparam int STATUS_W            = 2;
    localparam int FILL_W              = 5;
    localparam int ENTRY_W             = PRI_W + VAL_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // which logical slot the entry ram reads
    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_HEAD  = 2'd1,
        RD_PREV  = 2'd2,
        RD_PREV2 = 2'd3
    } rd_sel_t;

    typedef struct packed {
        logic    latch_req;
        rd_sel_t rd_sel;
        logic    wr_old;
        logic    wr_new;
        logic    pop;
        logic    push;
        logic    set_status;
        status_t status;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic req_remove;
        logic empty;
        logic full;
        logic k_is_one;
        logic prev_ge;
        logic out_free;
    } sts_t;

endpackage

// ----- src/spq_req_if.sv -----
`timescale 1ns / 1ps
// request channel: valid/ready with the request item
interface spq_req_if;
    import spq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [PRI_W-1:0]        priority_req;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output req_type, output priority_req, output value,
                    input ready);
    modport sink   (input valid, input req_type, input priority_req, input value,
                    output ready);
endinterface

// ----- src/spq_res_if.sv -----
`timescale 1ns / 1ps
// result channel: valid/ready with the result item
interface spq_res_if;
    import spq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] removed_value;
    logic [PRI_W-1:0]        removed_priority;
    logic [FILL_W-1:0]       fill_count;

    modport source (output valid, output status, output removed_value,
                    output removed_priority, output fill_count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input removed_priority, input fill_count, output ready);
endinterface

// ----- src/spq_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- src/spq_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer for insert, remove and result hand-off of the priority queue
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output spq_pkg::cmd_t cmd,
    input  spq_pkg::sts_t sts
);
    import spq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECODE  = 6'b000010,
        S_RD_HEAD = 6'b000100,
        S_INS_CMP = 6'b001000,
        S_INS_PUT = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        cmd.status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.req_remove)
                begin
                    if (sts.empty)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_UNDERFLOW;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_HEAD;
                        state_next = S_RD_HEAD;
                    end
                end
                else if (sts.full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OVERFLOW;
                    state_next     = S_DONE;
                end
                else if (sts.empty)
                begin
                    cmd.wr_new     = 1'b1;
                    cmd.push       = 1'b1;
                    cmd.set_status = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = RD_PREV;
                    state_next = S_INS_CMP;
                end
            end
            S_RD_HEAD:
            begin
                cmd.pop        = 1'b1;
                cmd.set_status = 1'b1;
                state_next     = S_DONE;
            end
            S_INS_CMP:
            begin
                // walk down from the tail, moving up every entry not below the new one
                if (sts.prev_ge)
                begin
                    cmd.wr_old = 1'b1;
                    if (sts.k_is_one)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_PREV2;
                    end
                end
                else
                begin
                    cmd.wr_new     = 1'b1;
                    cmd.push       = 1'b1;
                    cmd.set_status = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_new     = 1'b1;
                cmd.push       = 1'b1;
                cmd.set_status = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ----- src/spq_datapath.sv -----
`timescale 1ns / 1ps
// entry ram in circular order, fill count, head pointer and result register
module spq_datapath #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_pkg::cmd_t                   cmd,
    output spq_pkg::sts_t                   sts,
    input  logic                            req_type,
    input  logic [spq_pkg::PRI_W-1:0]       priority_req,
    input  logic signed [spq_pkg::VAL_W-1:0] value,
    spq_res_if.source                       res
);
    import spq_pkg::*;

    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(QUEUE_DEPTH - 1);

    logic                    req_remove_reg;
    logic [PRI_W-1:0]        req_pri_reg;
    logic signed [VAL_W-1:0] req_val_reg;
    logic [CNT_W-1:0]        k_reg;
    logic [CNT_W-1:0]        k_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [AW-1:0]           head_reg;
    logic [AW-1:0]           head_next;
    status_t                 pend_status_reg;
    logic signed [VAL_W-1:0] pend_val_reg;
    logic [PRI_W-1:0]        pend_pri_reg;
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic signed [VAL_W-1:0] out_val_reg;
    logic [PRI_W-1:0]        out_pri_reg;
    logic [FILL_W-1:0]       out_fill_reg;

    logic [CNT_W-1:0]        rd_lidx;
    logic [AW-1:0]           raddr;
    logic [AW-1:0]           waddr;
    logic                    we;
    logic [ENTRY_W-1:0]      wdata;
    logic [ENTRY_W-1:0]      rdata;
    logic [PRI_W-1:0]        rd_pri;
    logic signed [VAL_W-1:0] rd_val;
    logic [CNT_W+FILL_W-1:0] fill_ext;

    // logical slot to ram address, wrapping around the head
    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                              input logic [CNT_W-1:0] lidx);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(lidx);
        if (sum >= DEPTH_SUM)
        begin
            sum = sum - DEPTH_SUM;
        end
        return sum[AW-1:0];
    endfunction

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_HEAD:  rd_lidx = '0;
            RD_PREV:  rd_lidx = k_reg - 1'b1;
            RD_PREV2: rd_lidx = k_reg - CNT_W'(2);
            default:  rd_lidx = '0;
        endcase
    end

    assign raddr  = to_phys(head_reg, rd_lidx);
    assign waddr  = to_phys(head_reg, k_reg);
    assign we     = cmd.wr_old | cmd.wr_new;
    assign wdata  = cmd.wr_old ? rdata : {req_pri_reg, req_val_reg};
    assign rd_pri = rdata[ENTRY_W-1 -: PRI_W];
    assign rd_val = rdata[VAL_W-1:0];

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sts.req_remove = req_remove_reg;
    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg == DEPTH_CNT);
    assign sts.k_is_one   = (k_reg == CNT_W'(1));
    assign sts.prev_ge    = (rd_pri >= req_pri_reg);
    assign sts.out_free   = !out_valid_reg || res.ready;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
            head_next  = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
        end
    end

    always_comb
    begin
        k_next = k_reg;
        if (cmd.latch_req)
        begin
            k_next = count_reg;
        end
        else if (cmd.wr_old)
        begin
            k_next = k_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign fill_ext = (CNT_W + FILL_W)'(count_reg);

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (cmd.latch_req)
        begin
            req_remove_reg <= req_type;
            req_pri_reg    <= priority_req;
            req_val_reg    <= value;
            pend_val_reg   <= '0;
            pend_pri_reg   <= '0;
        end
        if (cmd.pop)
        begin
            pend_val_reg <= rd_val;
            pend_pri_reg <= rd_pri;
        end
        if (cmd.set_status)
        begin
            pend_status_reg <= cmd.status;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_val_reg    <= pend_val_reg;
            out_pri_reg    <= pend_pri_reg;
            out_fill_reg   <= fill_ext[FILL_W-1:0];
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.status           = out_status_reg;
    assign res.removed_value    = out_val_reg;
    assign res.removed_priority = out_pri_reg;
    assign res.fill_count       = out_fill_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fill count above queue depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && pend_status_reg == ST_OVERFLOW |-> count_reg == DEPTH_CNT)
        else $error("overflow reported on a queue that is not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && pend_status_reg == ST_UNDERFLOW |-> count_reg == '0)
        else $error("underflow reported on a queue that is not empty");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("remove did not lower the fill count by one");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_old && cmd.wr_new))
        else $error("shift write and new-entry write in the same cycle");
endmodule

// ----- src/sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps
// top level of the bounded sorted minimum-priority queue
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, priority_req, value
//   res      out  valid/ready   status, removed_value, removed_priority, fill_count
//
// one request at a time; req.ready is high only while the sequencer is idle
// insert: each stored entry with priority >= new one is moved up one slot, from the tail down,
//   by the single write port of the entry ram moving one entry per cycle
// remove reads the head entry and pops it; overflow and underflow go straight to the result
// the result register holds while res.ready is low; reset empties the queue at once
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_res_if.source res
);
    import spq_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic ctrl_ready;

    assign req.ready = ctrl_ready;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (ctrl_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req.req_type),
        .priority_req (req.priority_req),
        .value        (req.value),
        .res          (res)
    );
endmodule
